// ===== rtl/met_pkg.sv =====
// Shared types, constants and command/status structs for the Mandelbrot
// escape-time core. No dependencies.
`default_nettype none
package met_pkg;

  localparam int COUNT_WIDTH     = 16;
  localparam int INPUT_FRAC_BITS = 28;
  localparam int IN_W            = 32;
  localparam int FRAC            = 40;
  localparam int IN_SHIFT        = FRAC - INPUT_FRAC_BITS;
  localparam int IT_W            = COUNT_WIDTH + 1;
  localparam int MOD_W           = 32;

  localparam logic [63:0] FOUR_Q      = 64'd4 << FRAC;
  localparam logic [63:0] QUARTER_Q   = 64'd1 << (FRAC - 2);
  localparam logic [63:0] LOW_BOUND_Q = 64'd0 - (64'd3 << (FRAC - 2));
  localparam logic [63:0] HIGH_BOUND_Q = 64'd417814418554;
  localparam logic [63:0] INT64_MAX   = 64'h7FFF_FFFF_FFFF_FFFF;

  localparam logic [COUNT_WIDTH-1:0] MAX_ITER_RESET = COUNT_WIDTH'(1000);
  localparam logic [COUNT_WIDTH-1:0] MAX_ITER_ZERO  = COUNT_WIDTH'(10);

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_XX,
    OP_MUL_YY,
    OP_MUL_LL,
    OP_MUL_RR,
    OP_MUL_XY,
    OP_LX,
    OP_Q,
    OP_R,
    OP_NX,
    OP_NY,
    OP_INC,
    OP_RAD,
    OP_ROOT_STEP,
    OP_EMIT
  } met_op_t;

  typedef enum logic [2:0] {
    DST_XX,
    DST_YY,
    DST_LL,
    DST_RR,
    DST_P
  } met_dst_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_CXX, S_CXX_W,
    S_CYY, S_CYY_W,
    S_LX,
    S_CLL, S_CLL_W,
    S_Q, S_R,
    S_CRR, S_CRR_W,
    S_CARD,
    S_CHECK,
    S_AXY, S_ANX, S_AXY_W,
    S_ANY,
    S_AXX, S_AXX_W,
    S_AYY, S_AYY_W,
    S_RAD, S_ROOT,
    S_EMIT_Z, S_EMIT_F
  } met_state_t;

  typedef struct packed {
    met_op_t op;
    logic    emit_full;  // emit count and modulus rather than zeros
  } met_cmd_t;

  typedef struct packed {
    logic mul_busy;
    logic esc;
    logic it_lt_limit;
    logic card_in;
    logic root_last;
    logic out_full;
  } met_sts_t;

  typedef struct packed {
    logic        valid;
    met_dst_t    dst;
    logic [63:0] value;
    logic        frac_zero;
  } met_mul_res_t;

endpackage
`default_nettype wire

// ===== rtl/met_in_if.sv =====
// Input channel: one point c per item, valid/ready handshake.
// Depends on met_pkg.
`default_nettype none
interface met_in_if;
  logic                          valid;
  logic                          ready;
  logic signed [met_pkg::IN_W-1:0] point_re;
  logic signed [met_pkg::IN_W-1:0] point_im;

  modport source (output valid, output point_re, output point_im, input ready);
  modport sink   (input valid, input point_re, input point_im, output ready);
endinterface
`default_nettype wire

// ===== rtl/met_out_if.sv =====
// Result channel: escape count and final modulus, valid/ready handshake.
// Depends on met_pkg.
`default_nettype none
interface met_out_if;
  logic                             valid;
  logic                             ready;
  logic [met_pkg::COUNT_WIDTH-1:0]  escape_count;
  logic [met_pkg::MOD_W-1:0]        final_modulus;

  modport source (output valid, output escape_count, output final_modulus, input ready);
  modport sink   (input valid, input escape_count, input final_modulus, output ready);
endinterface
`default_nettype wire

// ===== rtl/met_mul.sv =====
// Sequential saturating Q24.40 multiplier: one 32x32 partial product a cycle.
// Depends on met_pkg.
`default_nettype none
module met_mul (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic [63:0]            a,
  input  logic [63:0]            b,
  input  logic                   sh39,
  input  met_pkg::met_dst_t      dst,
  output logic                   busy,
  output met_pkg::met_mul_res_t  res
);

  logic [63:0]       ma_r, mb_r, ma, mb;
  logic              neg_r, sh39_r;
  met_pkg::met_dst_t dst_r;
  logic [2:0]        phase_r;
  logic              busy_r;
  logic [63:0]       prod_r;
  logic [1:0]        pidx_r;
  logic              pv_r;
  logic [127:0]      acc_r;
  logic [127:0]      addend;
  logic [31:0]       opa, opb;
  logic [63:0]       m64, mag;
  logic              sat;

  assign ma = a[63] ? (64'd0 - a) : a;
  assign mb = b[63] ? (64'd0 - b) : b;

  always_comb begin
    opa = phase_r[1] ? ma_r[63:32] : ma_r[31:0];
    opb = phase_r[0] ? mb_r[63:32] : mb_r[31:0];
    case (pidx_r)
      2'd0:    addend = {64'd0, prod_r};
      2'd3:    addend = {prod_r, 64'd0};
      default: addend = {32'd0, prod_r, 32'd0};
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      phase_r <= 3'd0;
      pv_r    <= 1'b0;
    end else if (start && !busy_r) begin
      busy_r  <= 1'b1;
      phase_r <= 3'd0;
      pv_r    <= 1'b0;
    end else if (busy_r) begin
      pv_r    <= (phase_r <= 3'd3);
      phase_r <= phase_r + 3'd1;
      if (phase_r == 3'd5) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      ma_r   <= ma;
      mb_r   <= mb;
      neg_r  <= a[63] ^ b[63];
      sh39_r <= sh39;
      dst_r  <= dst;
      acc_r  <= 128'd0;
    end else begin
      if (pv_r) begin
        acc_r <= acc_r + addend;
      end
    end
    prod_r <= 64'(opa * opb);
    pidx_r <= phase_r[1:0];
  end

  // shift, saturate the magnitude, then restore the sign
  always_comb begin
    m64 = sh39_r ? acc_r[102:39] : acc_r[103:40];
    sat = sh39_r ? (|acc_r[127:102]) : (|acc_r[127:103]);
    mag = sat ? met_pkg::INT64_MAX : m64;
    res.valid     = busy_r && (phase_r == 3'd5);
    res.dst       = dst_r;
    res.value     = neg_r ? (64'd0 - mag) : mag;
    res.frac_zero = sh39_r ? (acc_r[38:0] == 39'd0) : (acc_r[39:0] == 40'd0);
  end

  assign busy = busy_r;

endmodule
`default_nettype wire

// ===== rtl/met_datapath.sv =====
// Datapath: orbit registers, cardioid terms, counter, digit-by-digit root
// and the result register. Depends on met_pkg and met_mul.
`default_nettype none
module met_datapath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  met_pkg::met_cmd_t               cmd,
  output met_pkg::met_sts_t               sts,
  input  logic [met_pkg::IN_W-1:0]        in_re,
  input  logic [met_pkg::IN_W-1:0]        in_im,
  input  logic                            cfg_we,
  input  logic [met_pkg::COUNT_WIDTH-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [met_pkg::COUNT_WIDTH-1:0] out_count,
  output logic [met_pkg::MOD_W-1:0]       out_mod
);

  logic [63:0] cr_r, ci_r, x_r, y_r, xx_r, yy_r, ll_r, rr_r, p_r, lx_r, q_r, r_r;
  logic        rr_fz_r;
  logic [met_pkg::IT_W-1:0]        it_r;
  logic [met_pkg::COUNT_WIDTH-1:0] limit_r, max_iter_r;
  logic [63:0] rad_r;
  logic [35:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  ridx_r;
  logic        out_valid_r;
  logic [met_pkg::COUNT_WIDTH-1:0] out_count_r;
  logic [met_pkg::MOD_W-1:0]       out_mod_r;

  logic        mul_start, mul_busy, mul_sh39;
  logic [63:0] mul_a, mul_b;
  met_pkg::met_dst_t     mul_dst;
  met_pkg::met_mul_res_t mul_res;

  logic [63:0] ld_re, ld_im, nx, ny, q_sum;
  logic [35:0] rem_sh, trial;
  logic        in_range, rr_ok;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      sat_add = s[64] ? 64'h8000_0000_0000_0000 : met_pkg::INT64_MAX;
    end else begin
      sat_add = s[63:0];
    end
  endfunction

  assign ld_re = 64'($signed(in_re)) <<< met_pkg::IN_SHIFT;
  assign ld_im = 64'($signed(in_im)) <<< met_pkg::IN_SHIFT;
  assign nx    = sat_add(xx_r - yy_r, cr_r);
  assign ny    = sat_add(p_r, ci_r);
  assign q_sum = sat_add(ll_r, yy_r);

  always_comb begin
    mul_start = 1'b1;
    mul_sh39  = 1'b0;
    mul_a     = x_r;
    mul_b     = x_r;
    mul_dst   = met_pkg::DST_XX;
    case (cmd.op)
      met_pkg::OP_MUL_XX: ;
      met_pkg::OP_MUL_YY: begin
        mul_a = y_r; mul_b = y_r; mul_dst = met_pkg::DST_YY;
      end
      met_pkg::OP_MUL_LL: begin
        mul_a = lx_r; mul_b = lx_r; mul_dst = met_pkg::DST_LL;
      end
      met_pkg::OP_MUL_RR: begin
        mul_a = r_r; mul_b = r_r; mul_dst = met_pkg::DST_RR;
      end
      met_pkg::OP_MUL_XY: begin
        mul_b = y_r; mul_dst = met_pkg::DST_P; mul_sh39 = 1'b1;
      end
      default: mul_start = 1'b0;
    endcase
  end

  met_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .sh39  (mul_sh39),
    .dst   (mul_dst),
    .busy  (mul_busy),
    .res   (mul_res)
  );

  assign rem_sh = {rem_r[33:0], rad_r[63:62]};
  assign trial  = {2'b00, root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (mul_res.valid) begin
      unique case (mul_res.dst)
        met_pkg::DST_XX: xx_r <= mul_res.value;
        met_pkg::DST_YY: yy_r <= mul_res.value;
        met_pkg::DST_LL: ll_r <= mul_res.value;
        met_pkg::DST_RR: begin
          rr_r    <= mul_res.value;
          rr_fz_r <= mul_res.frac_zero;
        end
        met_pkg::DST_P:  p_r  <= mul_res.value;
        default: ;
      endcase
    end
    case (cmd.op)
      met_pkg::OP_LOAD: begin
        cr_r    <= ld_re;
        ci_r    <= ld_im;
        x_r     <= ld_re;
        y_r     <= ld_im;
        it_r    <= met_pkg::IT_W'(1);
        limit_r <= max_iter_r;
      end
      met_pkg::OP_LX:  lx_r <= x_r - met_pkg::QUARTER_Q;
      met_pkg::OP_Q:   q_r  <= q_sum;
      met_pkg::OP_R:   r_r  <= {q_r[62:0], 1'b0} + lx_r;
      met_pkg::OP_NX:  x_r  <= nx;
      met_pkg::OP_NY:  y_r  <= ny;
      met_pkg::OP_INC: it_r <= it_r + met_pkg::IT_W'(1);
      met_pkg::OP_RAD: begin
        rad_r  <= xx_r + yy_r;
        rem_r  <= 36'd0;
        root_r <= 32'd0;
        ridx_r <= 5'd31;
      end
      met_pkg::OP_ROOT_STEP: begin
        rad_r  <= {rad_r[61:0], 2'b00};
        ridx_r <= ridx_r - 5'd1;
        if (rem_sh >= trial) begin
          rem_r  <= rem_sh - trial;
          root_r <= {root_r[30:0], 1'b1};
        end else begin
          rem_r  <= rem_sh;
          root_r <= {root_r[30:0], 1'b0};
        end
      end
      default: ;
    endcase
  end

  // configuration register and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_iter_r  <= met_pkg::MAX_ITER_RESET;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_iter_r <= (cfg_data == '0) ? met_pkg::MAX_ITER_ZERO : cfg_data;
      end
      if (cmd.op == met_pkg::OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == met_pkg::OP_EMIT) begin
      out_count_r <= cmd.emit_full ? it_r[met_pkg::COUNT_WIDTH-1:0] : '0;
      out_mod_r   <= cmd.emit_full ? root_r : '0;
    end
  end

  // cardioid: bounds on x, 0 < q < 4, then 2q + lx <= sqrt(q) squared out
  assign in_range = !($signed(x_r) < $signed(met_pkg::LOW_BOUND_Q)) &&
                    !($signed(x_r) > $signed(met_pkg::HIGH_BOUND_Q));
  assign rr_ok    = $signed(r_r) <= 0 || rr_r < q_r || (rr_r == q_r && rr_fz_r);

  always_comb begin
    sts.mul_busy    = mul_busy;
    sts.esc         = ({1'b0, xx_r} + {1'b0, yy_r}) >= {1'b0, met_pkg::FOUR_Q};
    sts.it_lt_limit = it_r < {1'b0, limit_r};
    sts.card_in     = in_range && (q_r != 64'd0) && (q_r < met_pkg::FOUR_Q) && rr_ok;
    sts.root_last   = (ridx_r == 5'd0);
    sts.out_full    = out_valid_r && !out_ready;
  end

  assign out_valid = out_valid_r;
  assign out_count = out_count_r;
  assign out_mod   = out_mod_r;

endmodule
`default_nettype wire

// ===== rtl/met_ctrl.sv =====
// Controller: sequences the cardioid test, the orbit loop, the two extra
// steps, the square root and the result. Depends on met_pkg.
`default_nettype none
module met_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  met_pkg::met_sts_t sts,
  output met_pkg::met_cmd_t cmd
);

  met_pkg::met_state_t state_r, state_nxt;
  logic post_r, post_nxt, second_r, second_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= met_pkg::S_IDLE;
      post_r   <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      post_r   <= post_nxt;
      second_r <= second_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    post_nxt      = post_r;
    second_nxt    = second_r;
    cmd.op        = met_pkg::OP_NONE;
    cmd.emit_full = 1'b0;
    in_ready      = 1'b0;
    unique case (state_r)
      met_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op     = met_pkg::OP_LOAD;
          post_nxt   = 1'b0;
          second_nxt = 1'b0;
          state_nxt  = met_pkg::S_CXX;
        end
      end
      met_pkg::S_CXX: begin
        cmd.op = met_pkg::OP_MUL_XX; state_nxt = met_pkg::S_CXX_W;
      end
      met_pkg::S_CXX_W: if (!sts.mul_busy) state_nxt = met_pkg::S_CYY;
      met_pkg::S_CYY: begin
        cmd.op = met_pkg::OP_MUL_YY; state_nxt = met_pkg::S_CYY_W;
      end
      met_pkg::S_CYY_W: if (!sts.mul_busy) state_nxt = met_pkg::S_LX;
      met_pkg::S_LX: begin
        cmd.op = met_pkg::OP_LX; state_nxt = met_pkg::S_CLL;
      end
      met_pkg::S_CLL: begin
        cmd.op = met_pkg::OP_MUL_LL; state_nxt = met_pkg::S_CLL_W;
      end
      met_pkg::S_CLL_W: if (!sts.mul_busy) state_nxt = met_pkg::S_Q;
      met_pkg::S_Q: begin
        cmd.op = met_pkg::OP_Q; state_nxt = met_pkg::S_R;
      end
      met_pkg::S_R: begin
        cmd.op = met_pkg::OP_R; state_nxt = met_pkg::S_CRR;
      end
      met_pkg::S_CRR: begin
        cmd.op = met_pkg::OP_MUL_RR; state_nxt = met_pkg::S_CRR_W;
      end
      met_pkg::S_CRR_W: if (!sts.mul_busy) state_nxt = met_pkg::S_CARD;
      met_pkg::S_CARD: begin
        state_nxt = sts.card_in ? met_pkg::S_EMIT_Z : met_pkg::S_CHECK;
      end
      met_pkg::S_CHECK: begin
        if (sts.esc) begin
          if (sts.it_lt_limit) begin
            post_nxt  = 1'b1;
            state_nxt = met_pkg::S_AXY;
          end else begin
            state_nxt = met_pkg::S_EMIT_Z;
          end
        end else begin
          cmd.op    = met_pkg::OP_INC;
          state_nxt = sts.it_lt_limit ? met_pkg::S_AXY : met_pkg::S_EMIT_Z;
        end
      end
      met_pkg::S_AXY: begin
        cmd.op = met_pkg::OP_MUL_XY; state_nxt = met_pkg::S_ANX;
      end
      met_pkg::S_ANX: begin
        cmd.op = met_pkg::OP_NX; state_nxt = met_pkg::S_AXY_W;
      end
      met_pkg::S_AXY_W: if (!sts.mul_busy) state_nxt = met_pkg::S_ANY;
      met_pkg::S_ANY: begin
        cmd.op = met_pkg::OP_NY; state_nxt = met_pkg::S_AXX;
      end
      met_pkg::S_AXX: begin
        cmd.op = met_pkg::OP_MUL_XX; state_nxt = met_pkg::S_AXX_W;
      end
      met_pkg::S_AXX_W: if (!sts.mul_busy) state_nxt = met_pkg::S_AYY;
      met_pkg::S_AYY: begin
        cmd.op = met_pkg::OP_MUL_YY; state_nxt = met_pkg::S_AYY_W;
      end
      met_pkg::S_AYY_W: begin
        if (!sts.mul_busy) begin
          if (!post_r) begin
            state_nxt = met_pkg::S_CHECK;
          end else if (!second_r) begin
            second_nxt = 1'b1;
            state_nxt  = met_pkg::S_AXY;
          end else begin
            state_nxt = met_pkg::S_RAD;
          end
        end
      end
      met_pkg::S_RAD: begin
        cmd.op = met_pkg::OP_RAD; state_nxt = met_pkg::S_ROOT;
      end
      met_pkg::S_ROOT: begin
        cmd.op = met_pkg::OP_ROOT_STEP;
        if (sts.root_last) state_nxt = met_pkg::S_EMIT_F;
      end
      met_pkg::S_EMIT_Z: begin
        if (!sts.out_full) begin
          cmd.op    = met_pkg::OP_EMIT;
          state_nxt = met_pkg::S_IDLE;
        end
      end
      met_pkg::S_EMIT_F: begin
        if (!sts.out_full) begin
          cmd.op        = met_pkg::OP_EMIT;
          cmd.emit_full = 1'b1;
          state_nxt     = met_pkg::S_IDLE;
        end
      end
      default: state_nxt = met_pkg::S_IDLE;
    endcase
  end

  a_mul_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == met_pkg::OP_MUL_XX || cmd.op == met_pkg::OP_MUL_YY ||
     cmd.op == met_pkg::OP_MUL_LL || cmd.op == met_pkg::OP_MUL_RR ||
     cmd.op == met_pkg::OP_MUL_XY) |-> !sts.mul_busy)
    else $error("multiplier issued while busy");

  a_emit_room: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == met_pkg::OP_EMIT) |-> !sts.out_full)
    else $error("result overwritten before taken");

  a_root_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == met_pkg::S_ROOT && sts.root_last) |=> (state_r == met_pkg::S_EMIT_F))
    else $error("root did not end in emit");

  a_second_post: assert property (@(posedge clk) disable iff (!rst_n)
    second_r |-> post_r)
    else $error("second extra step without escape");

endmodule
`default_nettype wire

// ===== rtl/mandelbrot_escape_time_core.sv =====
// Top level of the Mandelbrot escape-time core: controller plus datapath.
// Depends on met_pkg, met_in_if, met_out_if, met_ctrl, met_datapath.
//
// Usage:
//   in_item  : one point c (point_re, point_im, signed Q4.28) per item.
//   out_item : escape_count and final_modulus (unsigned Q12.20) per item,
//              exactly one result for each point, in order.
//   cfg_we / cfg_data : iteration limit, written while idle; 0 stores 10.
// Timing is set by the single shared 32x32 multiplier and the
// one-bit-a-cycle root. Each 64-bit product holds the controller from
// issue through the partial products until it sees the multiplier free.
//   Work per point: load and cardioid test, each orbit step (check plus
//   advance), the two extra steps, the square root and the result; a
//   point in the cardioid goes straight to its result, and a point that
//   reaches the limit without escaping skips the extra steps and the root.
//   One point is worked on at a time; the next is taken once the previous
//   result sits in the output register.
// Reset (rst_n low at a clock edge) empties the output register, returns the
//   controller to idle and restores the limit to 1000.
// A stalled receiver holds the result; the core finishes the next point
//   and then waits until the result register is free.
`default_nettype none
module mandelbrot_escape_time_core (
  input  logic                            clk,
  input  logic                            rst_n,
  met_in_if.sink                          in_item,
  met_out_if.source                       out_item,
  input  logic                            cfg_we,
  input  logic [met_pkg::COUNT_WIDTH-1:0] cfg_data
);

  met_pkg::met_cmd_t cmd;
  met_pkg::met_sts_t sts;
  logic              in_ready;

  // sequence the work of one item
  met_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // hold the orbit, the counter, the root and the result register
  met_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_re     (in_item.point_re),
    .in_im     (in_item.point_im),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .out_valid (out_item.valid),
    .out_ready (out_item.ready),
    .out_count (out_item.escape_count),
    .out_mod   (out_item.final_modulus)
  );

  assign in_item.ready = in_ready;

endmodule
`default_nettype wire
